[rtl/mfde_pkg.sv]
// ----------------------------------------------------------------------------
// mfde_pkg: shared types and constants of the frame store draw engine
// Frame store geometry, command codes and controller/datapath interface.
// ----------------------------------------------------------------------------
package mfde_pkg;

    localparam int WIDTH       = 128;
    localparam int HEIGHT      = 64;
    localparam int ROW_BYTES   = (WIDTH + 7) / 8;
    localparam int HALF_ROWS   = HEIGHT / 2;
    localparam int STORE_BYTES = ROW_BYTES * HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COL_W       = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

    localparam logic [2:0] CMD_PLOT  = 3'd0;
    localparam logic [2:0] CMD_HLINE = 3'd1;
    localparam logic [2:0] CMD_VLINE = 3'd2;
    localparam logic [2:0] CMD_BOX   = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;
    localparam logic [2:0] CMD_FLUSH = 3'd5;

    localparam logic [7:0] BYTE_GFX_EXT = 8'h34;
    localparam logic [7:0] BYTE_GFX_ON  = 8'h36;
    localparam logic [7:0] BYTE_ADDR    = 8'h80;
    localparam logic [7:0] BYTE_LOW7    = 8'h7f;

    typedef enum logic [2:0] {
        SRC_GFX_EXT,
        SRC_GFX_ON,
        SRC_ROW,
        SRC_ADDR0,
        SRC_DATA
    } out_src_t;

    typedef struct packed {
        logic       load_item;
        logic       line_setup;
        logic [1:0] line_sel;
        logic       mem_rd;
        logic       mem_wr;
        logic       line_step;
        logic       clr_start;
        logic       clr_wr;
        logic       out_load;
        out_src_t   out_src;
        logic       fl_start;
        logic       fl_rd;
        logic       fl_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       flush_ok;
        logic       row_zero;
        logic       line_empty;
        logic       line_end;
        logic       clr_last;
        logic       out_free;
        logic       fl_last;
    } dp_status_t;

endpackage

[rtl/mfde_ram.sv]
// ----------------------------------------------------------------------------
// mfde_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mfde_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mfde_dp.sv]
// ----------------------------------------------------------------------------
// mfde_dp: draw engine datapath
// Item registers, line walker, clear sweep, flush address and output register.
// ----------------------------------------------------------------------------
module mfde_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mfde_pkg::ctrl_cmd_t    ctl,
    output mfde_pkg::dp_status_t   sts,
    input  logic [2:0]             command,
    input  logic [7:0]             x0,
    input  logic [7:0]             y0,
    input  logic [7:0]             x1,
    input  logic [7:0]             y1,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   is_command,
    output logic [7:0]             out_byte,
    output logic                   last
);

    import mfde_pkg::*;

    logic [2:0] cmd_reg;
    logic [7:0] x0_reg, y0_reg, x1_reg, y1_reg;

    logic       vert_reg, empty_reg;
    logic [7:0] fix_reg, lo_reg, hi_reg, cur_reg, end_reg;

    logic [ADDR_W-1:0] clr_reg;
    logic              fhalf_reg;
    logic [COL_W-1:0]  fcol_reg;

    logic       ov_reg, oc_reg, ol_reg;
    logic [7:0] ob_reg;

    logic [7:0] a_s, b_s, f_s, lo_s, hi_s, hcl_s;
    logic       v_s, on_s;

    logic [ADDR_W-1:0] line_addr, fl_addr, waddr, raddr;
    logic [7:0]        mask, rdata, wdata;
    logic [7:0]        fl_row;
    logic              fl_last_s;

    // capture the item
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg <= command;
            x0_reg  <= x0;
            y0_reg  <= y0;
            x1_reg  <= x1;
            y1_reg  <= y1;
        end
    end

    // pick the endpoints of the current line
    always_comb
    begin
        a_s = x0_reg;
        b_s = x1_reg;
        f_s = y0_reg;
        v_s = 1'b0;
        case (cmd_reg)
            CMD_PLOT:  b_s = x0_reg;
            CMD_HLINE: ;
            CMD_VLINE:
            begin
                a_s = y0_reg;
                b_s = y1_reg;
                f_s = x0_reg;
                v_s = 1'b1;
            end
            default:
            begin
                case (ctl.line_sel)
                    2'd0: ;
                    2'd1: f_s = y1_reg;
                    2'd2:
                    begin
                        a_s = y0_reg;
                        b_s = y1_reg;
                        f_s = x0_reg;
                        v_s = 1'b1;
                    end
                    default:
                    begin
                        a_s = y0_reg;
                        b_s = y1_reg;
                        f_s = x1_reg;
                        v_s = 1'b1;
                    end
                endcase
            end
        endcase
        lo_s = (a_s > b_s) ? b_s : a_s;
        hi_s = (a_s > b_s) ? a_s : b_s;
        if (v_s)
        begin
            on_s  = ({1'b0, f_s} < 9'(WIDTH)) && ({1'b0, lo_s} < 9'(HEIGHT));
            hcl_s = ({1'b0, hi_s} >= 9'(HEIGHT)) ? 8'(HEIGHT - 1) : hi_s;
        end
        else
        begin
            on_s  = ({1'b0, lo_s} < 9'(WIDTH)) && ({1'b0, f_s} < 9'(HEIGHT));
            hcl_s = ({1'b0, hi_s} >= 9'(WIDTH)) ? 8'(WIDTH - 1) : hi_s;
        end
    end

    // set up and advance the line walker
    always_ff @(posedge clk)
    begin
        if (ctl.line_setup)
        begin
            vert_reg  <= v_s;
            empty_reg <= !on_s;
            fix_reg   <= f_s;
            lo_reg    <= lo_s;
            hi_reg    <= hcl_s;
            cur_reg   <= v_s ? lo_s : (lo_s >> 3);
            end_reg   <= v_s ? hcl_s : (hcl_s >> 3);
        end
        else if (ctl.line_step)
        begin
            cur_reg <= cur_reg + 8'd1;
        end
    end

    // byte address and pixel mask of the current step
    always_comb
    begin
        logic [7:0] px;
        px = 8'd0;
        if (vert_reg)
        begin
            line_addr = ADDR_W'(cur_reg * ROW_BYTES + (fix_reg >> 3));
            mask      = 8'h80 >> fix_reg[2:0];
        end
        else
        begin
            line_addr = ADDR_W'(fix_reg * ROW_BYTES + cur_reg);
            for (int j = 0; j < 8; j++)
            begin
                px = 8'((cur_reg << 3) + j);
                mask[7-j] = (px >= lo_reg) && (px <= hi_reg);
            end
        end
    end

    // clear sweep counter; reset starts a sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (ctl.clr_start)
        begin
            clr_reg <= '0;
        end
        else if (ctl.clr_wr)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // flush byte position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fhalf_reg <= 1'b0;
            fcol_reg  <= '0;
        end
        else if (ctl.fl_start)
        begin
            fhalf_reg <= 1'b0;
            fcol_reg  <= '0;
        end
        else if (ctl.fl_step)
        begin
            if (fcol_reg == COL_W'(ROW_BYTES - 1))
            begin
                fcol_reg  <= '0;
                fhalf_reg <= 1'b1;
            end
            else
            begin
                fcol_reg <= fcol_reg + 1'b1;
            end
        end
    end

    assign fl_row    = fhalf_reg ? (y0_reg + 8'(HALF_ROWS)) : y0_reg;
    assign fl_addr   = ADDR_W'(fl_row * ROW_BYTES + fcol_reg);
    assign fl_last_s = fhalf_reg && (fcol_reg == COL_W'(ROW_BYTES - 1));

    // store ports
    assign raddr = ctl.fl_rd ? fl_addr : line_addr;
    assign waddr = ctl.clr_wr ? clr_reg : line_addr;
    assign wdata = ctl.clr_wr ? 8'h00 : (rdata | mask);

    mfde_ram #(
        .DW    (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ctl.mem_wr || ctl.clr_wr),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ctl.mem_rd || ctl.fl_rd),
        .raddr (raddr),
        .rdata (rdata)
    );

    // output register: load a beat, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            oc_reg <= 1'b1;
            ol_reg <= 1'b0;
            case (ctl.out_src)
                SRC_GFX_EXT: ob_reg <= BYTE_GFX_EXT;
                SRC_GFX_ON:  ob_reg <= BYTE_GFX_ON;
                SRC_ROW:     ob_reg <= BYTE_ADDR | (y0_reg & BYTE_LOW7);
                SRC_ADDR0:   ob_reg <= BYTE_ADDR;
                default:
                begin
                    oc_reg <= 1'b0;
                    ol_reg <= fl_last_s;
                    ob_reg <= rdata;
                end
            endcase
        end
    end

    assign out_valid  = ov_reg;
    assign is_command = oc_reg;
    assign out_byte   = ob_reg;
    assign last       = ol_reg;

    // status back to the controller
    assign sts.cmd        = cmd_reg;
    assign sts.flush_ok   = ({1'b0, y0_reg} < 9'(HALF_ROWS));
    assign sts.row_zero   = (y0_reg == 8'd0);
    assign sts.line_empty = empty_reg;
    assign sts.line_end   = (cur_reg == end_reg);
    assign sts.clr_last   = (clr_reg == ADDR_W'(STORE_BYTES - 1));
    assign sts.out_free   = !ov_reg || out_ready;
    assign sts.fl_last    = fl_last_s;

endmodule

[rtl/mfde_ctrl.sv]
// ----------------------------------------------------------------------------
// mfde_ctrl: draw engine controller
// Sequences item decode, line read-modify-write, clear sweep and flush runs.
// ----------------------------------------------------------------------------
module mfde_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output mfde_pkg::ctrl_cmd_t    ctl,
    input  mfde_pkg::dp_status_t   sts
);

    import mfde_pkg::*;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DISP,
        S_LSET,
        S_LCHK,
        S_LRD,
        S_LWR,
        S_LNEXT,
        S_H34,
        S_H36,
        S_HROW,
        S_H80,
        S_FRD,
        S_FLD
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    // decode commands and next state
    always_comb
    begin
        ctl            = '0;
        ctl.out_src    = SRC_DATA;
        ctl.line_sel   = sel_reg;
        state_next     = state_reg;
        sel_next       = sel_reg;
        in_ready       = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                ctl.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                sel_next = 2'd0;
                case (sts.cmd)
                    CMD_PLOT, CMD_HLINE, CMD_VLINE, CMD_BOX: state_next = S_LSET;
                    CMD_CLEAR:
                    begin
                        ctl.clr_start = 1'b1;
                        state_next    = S_CLR;
                    end
                    CMD_FLUSH:
                    begin
                        if (!sts.flush_ok)
                            state_next = S_IDLE;
                        else if (sts.row_zero)
                            state_next = S_H34;
                        else
                            state_next = S_HROW;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_LSET:
            begin
                ctl.line_setup = 1'b1;
                state_next     = S_LCHK;
            end
            S_LCHK:
            begin
                state_next = sts.line_empty ? S_LNEXT : S_LRD;
            end
            S_LRD:
            begin
                ctl.mem_rd = 1'b1;
                state_next = S_LWR;
            end
            S_LWR:
            begin
                ctl.mem_wr = 1'b1;
                if (sts.line_end)
                begin
                    state_next = S_LNEXT;
                end
                else
                begin
                    ctl.line_step = 1'b1;
                    state_next    = S_LRD;
                end
            end
            S_LNEXT:
            begin
                if ((sts.cmd == CMD_BOX) && (sel_reg != 2'd3))
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_LSET;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_H34:
            begin
                ctl.out_src = SRC_GFX_EXT;
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_H36;
                end
            end
            S_H36:
            begin
                ctl.out_src = SRC_GFX_ON;
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_HROW;
                end
            end
            S_HROW:
            begin
                ctl.out_src = SRC_ROW;
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_H80;
                end
            end
            S_H80:
            begin
                ctl.out_src  = SRC_ADDR0;
                ctl.fl_start = 1'b1;
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_FRD;
                end
            end
            S_FRD:
            begin
                ctl.fl_rd  = 1'b1;
                state_next = S_FLD;
            end
            S_FLD:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    if (sts.fl_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.fl_step = 1'b1;
                        state_next  = S_FRD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // hold state; reset enters the clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            sel_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

[rtl/monochrome_framebuffer_draw_engine_core.sv]
// ----------------------------------------------------------------------------
// monochrome_framebuffer_draw_engine_core: 1 bpp frame store draw engine
// Input channel (in_valid/in_ready) takes one drawing command per beat:
// plot, hline, vline, box, clear or flush of one display row. Output channel
// (out_valid/out_ready) gives one byte per beat with is_command and last.
// A byte is set in the store by read-modify-write over the RAM's read and
// write ports, a read state then a write state per store byte touched: an
// hline walks up to ROW_BYTES bytes, a vline up to HEIGHT bytes, a box up
// to four such lines, plus a setup and a check state per line. Clear sweeps
// the store one byte per cycle (STORE_BYTES bytes, 1024 by default). A flush
// gives two or four command beats and then 2*ROW_BYTES data beats, each data
// byte needing a read state and then a load state. After reset the same
// clearing sweep runs, and in_ready stays low until it is done. The output
// register holds a beat while out_ready is low, and the flush sequencer
// waits on it; in_ready is high only while no command is being worked on.
// ----------------------------------------------------------------------------
module monochrome_framebuffer_draw_engine_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] command,
    input  logic [7:0] x0,
    input  logic [7:0] y0,
    input  logic [7:0] x1,
    input  logic [7:0] y1,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_command,
    output logic [7:0] out_byte,
    output logic       last
);

    import mfde_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t sts;

    // controller
    mfde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .ctl      (ctl),
        .sts      (sts)
    );

    // datapath with frame store
    mfde_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .command    (command),
        .x0         (x0),
        .y0         (y0),
        .x1         (x1),
        .y1         (y1),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .is_command (is_command),
        .out_byte   (out_byte),
        .last       (last)
    );

endmodule
